// ===== src/lrs_pkg.sv =====
// Shared types and constants for the longest repeated substring block.
`timescale 1ns / 1ps
package lrs_pkg;

	localparam int unsigned LRS_CHAR_W = 8;
	localparam int unsigned LRS_LEN_W  = 8;
	localparam logic [LRS_LEN_W-1:0] LRS_LEN_MAX = '1;
	// Hit bits folded by one register of the reduction tree
	localparam int unsigned LRS_GROUP  = 64;

	// State a cell hands to its right-hand neighbor (already cleared on a new string)
	typedef struct packed {
		logic                 valid;
		logic [LRS_LEN_W-1:0] match;
	} lrs_link_t;

	// Controls broadcast from the top level to every cell
	typedef struct packed {
		logic                  step;
		logic                  first;
		logic [LRS_CHAR_W-1:0] chr;
		logic [LRS_LEN_W-1:0]  best;
	} lrs_bcast_t;

endpackage

// ===== src/longest_repeating_substring_top.sv =====
// Top level of the longest repeated substring block: cell chain, reduction and control.
`timescale 1ns / 1ps
// Usage:
//   Input stream: s_tdata[7:0] carries one character per word, s_tuser marks the
//   first character of a new string and clears all stored positions first.
//   Output stream: one word per input word; m_tdata[7:0] is the longest length of
//   a substring seen twice so far (copies may overlap), m_tuser is set once the
//   string ran past MAX_LEN characters; such characters are dropped.
//   Each position of the string lives in its own cell of a chain of MAX_LEN cells;
//   a cell compares the new character with its stored one and takes its left
//   neighbor's match length, all cells in the same cycle.
//   The result passes the cell hit flags, the registered OR tree and the merge step
//   on its way into the output register, which raises m_tvalid.
//   A new word is taken only once the last one has passed reduce and merge, since
//   the hit flags and the registered OR tree decide if the best grew by one.
//   The next word is taken while a result waits in the output register; if the
//   receiver stalls, the block holds its finished result and stops in the merge
//   step until m_tready returns.
//   Reset empties every cell and clears the best length and overflow flag; a word
//   without s_tuser after reset continues the empty string.
module longest_repeating_substring_top #(
	parameter int unsigned MAX_LEN = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tuser,   // [0] first
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] longest_len
	output logic       m_tuser    // [0] overflow
);
	import lrs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_REDUCE = 3'b010,
		ST_MERGE  = 3'b100
	} state_t;

	state_t               state_q;
	logic [LRS_LEN_W-1:0] best_q;
	logic                 overflowed_q;
	logic                 take;
	logic                 ovf;
	logic                 any;
	logic                 out_free;
	logic [LRS_LEN_W-1:0] best_next;
	lrs_bcast_t           bc;
	lrs_link_t            link [MAX_LEN:0];
	logic [MAX_LEN-1:0]   hits;
	logic [MAX_LEN-1:0]   vld;

	assign s_tready = (state_q == ST_IDLE);
	assign take     = s_tvalid & s_tready;
	assign ovf      = link[MAX_LEN].valid;
	assign out_free = !m_tvalid || m_tready;

	assign bc.first = take & s_tuser;
	assign bc.step  = take & ~ovf;
	assign bc.chr   = s_tdata;
	assign bc.best  = best_q;

	// Chain of position cells; cell zero sees a full, zero-length neighbor
	assign link[0] = '{valid: 1'b1, match: '0};

	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		lrs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.bc     (bc),
			.left   (link[k]),
			.right  (link[k+1]),
			.hit_q  (hits[k])
		);
		assign vld[k] = link[k+1].valid;
	end

	lrs_reduce #(
		.N (MAX_LEN)
	) u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (state_q == ST_REDUCE),
		.hit    (hits),
		.any    (any)
	);

	// Best grows by at most one per character
	assign best_next = best_q + {{(LRS_LEN_W-1){1'b0}}, any};

	// Sequence take, reduce and merge; hold the result for the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			best_q       <= '0;
			overflowed_q <= 1'b0;
			m_tvalid     <= 1'b0;
		end else begin
			if (state_q == ST_MERGE && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (s_tuser) begin
							best_q       <= '0;
							overflowed_q <= 1'b0;
						end else if (ovf) begin
							overflowed_q <= 1'b1;
						end
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (out_free) begin
						best_q  <= best_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (state_q == ST_MERGE && out_free) begin
			m_tdata <= best_next;
			m_tuser <= overflowed_q;
		end
	end

	// Occupied cells always form a prefix of the chain
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(vld & (vld + {{(MAX_LEN-1){1'b0}}, 1'b1})) == '0)
		else $error("occupied cells are not a prefix of the chain");

	// Best length only falls when a new string starts
	a_best_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(best_q < $past(best_q)) |-> $past(take && s_tuser))
		else $error("best length fell inside a string");

	// A result appears only out of the merge step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_MERGE))
		else $error("result loaded outside the merge step");

	// Overflow is raised only when the chain was full
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(overflowed_q) |-> $past(vld[MAX_LEN-1] && take))
		else $error("overflow raised with free cells");

endmodule

// ===== src/lrs_cell.sv =====
// One string position: stored character, suffix-match length and a new-best flag.
`timescale 1ns / 1ps
module lrs_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  lrs_pkg::lrs_bcast_t bc,
	input  lrs_pkg::lrs_link_t  left,
	output lrs_pkg::lrs_link_t  right,
	output logic              hit_q
);
	import lrs_pkg::*;

	logic [LRS_CHAR_W-1:0] hist_q;
	logic                  valid_q;
	logic [LRS_LEN_W-1:0]  match_q;
	logic                  valid_eff;
	logic                  eq;
	logic [LRS_LEN_W-1:0]  ext_len;

	// Treat the cell as empty while a new string is being started
	assign valid_eff   = valid_q & ~bc.first;
	assign right.valid = valid_eff;
	assign right.match = bc.first ? '0 : match_q;

	assign eq      = (hist_q == bc.chr);
	assign ext_len = (left.match == LRS_LEN_MAX) ? LRS_LEN_MAX : left.match + 1'b1;

	// Update length and occupancy on each taken character that is not dropped on overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			hit_q <= bc.step && valid_eff && eq && (left.match == bc.best) &&
				(bc.best != LRS_LEN_MAX);
			if (bc.step) begin
				if (valid_eff) begin
					match_q <= eq ? ext_len : '0;
				end else if (left.valid) begin
					valid_q <= 1'b1;
					match_q <= '0;
				end else begin
					valid_q <= 1'b0;
					match_q <= '0;
				end
			end
		end
	end

	// Store the character in the first free cell
	always_ff @(posedge clk) begin
		if (bc.step && !valid_eff && left.valid) begin
			hist_q <= bc.chr;
		end
	end

endmodule

// ===== src/lrs_reduce.sv =====
// Registered OR tree over the cell hit flags.
`timescale 1ns / 1ps
module lrs_reduce #(
	parameter int unsigned N = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic [N-1:0] hit,
	output logic         any
);
	import lrs_pkg::*;

	localparam int unsigned NG = (N + LRS_GROUP - 1) / LRS_GROUP;

	logic [NG*LRS_GROUP-1:0] hit_pad;
	logic [NG-1:0]           grp_q;

	// Pad the hit vector to whole groups
	always_comb begin
		hit_pad        = '0;
		hit_pad[N-1:0] = hit;
	end

	// Fold each group and hold it until the next load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
		end else if (load) begin
			for (int g = 0; g < NG; g++) begin
				grp_q[g] <= |hit_pad[g*LRS_GROUP +: LRS_GROUP];
			end
		end
	end

	assign any = |grp_q;

endmodule
